>>> rtl/core/ptcf_pkg.sv
// shared widths, constants, types and helper functions of the point transform crop filter
package ptcf_pkg;

	// field widths and fixed-point formats
	localparam int COORD_BITS = 16;
	localparam int COEF_BITS  = 16;
	localparam int REG_W      = 48;
	localparam int TAN_W      = 16;
	localparam int TAN_FRAC   = 12;
	localparam int COLOR_W    = 8;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 3;

	// derived datapath widths
	localparam int KFRAC   = COEF_BITS - 2;
	localparam int PROD_W  = COORD_BITS + COEF_BITS;
	localparam int SUM_W   = PROD_W + 2;
	localparam int ROT_W   = SUM_W - KFRAC;
	localparam int BODY_W  = ROT_W + 1;
	localparam int MAG_W   = ROT_W;
	localparam int CROSS_W = TAN_W + MAG_W;

	// half an lsb for rounding the rotated sum
	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(longint'(1) << (KFRAC - 1));

	// saturation limits of the output coordinates
	localparam logic signed [BODY_W-1:0] COORD_MAX_B =
		BODY_W'((longint'(1) << (COORD_BITS - 1)) - 1);
	localparam logic signed [BODY_W-1:0] COORD_MIN_B =
		BODY_W'(-(longint'(1) << (COORD_BITS - 1)));

	// crop limits, 12 fraction bits
	localparam logic signed [BODY_W-1:0] LIM_015  = BODY_W'(614);
	localparam logic signed [BODY_W-1:0] LIM_005  = BODY_W'(205);
	localparam logic signed [BODY_W-1:0] LIM_N005 = BODY_W'(-205);
	localparam logic signed [BODY_W-1:0] LIM_050  = BODY_W'(2048);
	localparam logic signed [BODY_W-1:0] LIM_N050 = BODY_W'(-2048);
	localparam logic signed [BODY_W-1:0] LIM_035  = BODY_W'(1434);
	localparam logic signed [BODY_W-1:0] LIM_N035 = BODY_W'(-1434);
	localparam logic signed [BODY_W-1:0] LIM_010  = BODY_W'(410);
	localparam logic signed [BODY_W-1:0] LIM_N010 = BODY_W'(-410);
	localparam logic signed [BODY_W-1:0] LIM_080  = BODY_W'(3277);
	localparam logic signed [BODY_W-1:0] LIM_N080 = BODY_W'(-3277);

	// tangent of 40 degrees, Q4.12
	localparam logic [TAN_W-1:0] TAN40 = TAN_W'(3437);

	// crop rule codes
	localparam logic [MODE_W-1:0] MODE_FRONT     = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_CHIN      = MODE_W'(2);
	localparam logic [MODE_W-1:0] MODE_LEFT      = MODE_W'(3);
	localparam logic [MODE_W-1:0] MODE_RIGHT     = MODE_W'(4);
	localparam logic [MODE_W-1:0] MODE_REAR_DOWN = MODE_W'(5);
	localparam logic [MODE_W-1:0] MODE_RESET     = MODE_FRONT;

	// register indexes of the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOUNT_MODE = 3'd0,
		REG_ROT_ROW_X  = 3'd1,
		REG_ROT_ROW_Y  = 3'd2,
		REG_ROT_ROW_Z  = 3'd3,
		REG_OFFSET_XYZ = 3'd4,
		REG_TAN_SIDE   = 3'd5,
		REG_TAN_BACK   = 3'd6
	} cfg_reg_t;

	// configuration register set
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [REG_W-1:0]  rot_x;
		logic [REG_W-1:0]  rot_y;
		logic [REG_W-1:0]  rot_z;
		logic [REG_W-1:0]  offset;
		logic [TAN_W-1:0]  tan_side;
		logic [TAN_W-1:0]  tan_back;
	} cfg_t;

	// rotated point with its colour
	typedef struct packed {
		logic signed [ROT_W-1:0] px;
		logic signed [ROT_W-1:0] py;
		logic signed [ROT_W-1:0] pz;
		logic [COLOR_W-1:0]      blue;
		logic [COLOR_W-1:0]      green;
		logic [COLOR_W-1:0]      red;
	} rot_pt_t;

	// signed coefficient k of a packed row, zero above the register
	function automatic logic signed [COEF_BITS-1:0] coef_field(
		input logic [REG_W-1:0] row, input int k);
		logic [REG_W+COEF_BITS-1:0] wide;
		wide = {{COEF_BITS{1'b0}}, row} >> (k * COEF_BITS);
		if (k * COEF_BITS >= REG_W) begin
			return '0;
		end
		return $signed(wide[COEF_BITS-1:0]);
	endfunction

	// signed coordinate k of the packed offset, zero above the register
	function automatic logic signed [COORD_BITS-1:0] coord_field(
		input logic [REG_W-1:0] row, input int k);
		logic [REG_W+COORD_BITS-1:0] wide;
		wide = {{COORD_BITS{1'b0}}, row} >> (k * COORD_BITS);
		if (k * COORD_BITS >= REG_W) begin
			return '0;
		end
		return $signed(wide[COORD_BITS-1:0]);
	endfunction

	// magnitude of a rotated coordinate
	function automatic logic [MAG_W-1:0] mag_rot(input logic signed [ROT_W-1:0] v);
		logic signed [ROT_W-1:0] neg;
		neg = -v;
		return v[ROT_W-1] ? MAG_W'(neg) : MAG_W'(v);
	endfunction

	// tangent times magnitude
	function automatic logic [CROSS_W-1:0] tan_mul(
		input logic [TAN_W-1:0] t, input logic [MAG_W-1:0] m);
		return {{MAG_W{1'b0}}, t} * {{TAN_W{1'b0}}, m};
	endfunction

	// |num / den| < t as |num| * 4096 < t * |den|, never true for zero den
	function automatic logic below(input logic [MAG_W-1:0] num,
		input logic [MAG_W-1:0] den, input logic [CROSS_W-1:0] prod);
		logic [CROSS_W-1:0] lhs;
		lhs = {{(TAN_W - TAN_FRAC){1'b0}}, num, {TAN_FRAC{1'b0}}};
		return (den != '0) && (lhs < prod);
	endfunction

	// saturate a body coordinate to the output range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [BODY_W-1:0] v);
		if (v > COORD_MAX_B) begin
			return COORD_MAX_B[COORD_BITS-1:0];
		end
		if (v < COORD_MIN_B) begin
			return COORD_MIN_B[COORD_BITS-1:0];
		end
		return v[COORD_BITS-1:0];
	endfunction

endpackage

>>> rtl/core/ptcf_rotate.sv
// rotation stages: matrix products, then row sums with rounding
module ptcf_rotate (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ptcf_pkg::cfg_t                         cfg,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [ptcf_pkg::COORD_BITS-1:0] cam_x,
	input  logic signed [ptcf_pkg::COORD_BITS-1:0] cam_y,
	input  logic signed [ptcf_pkg::COORD_BITS-1:0] cam_z,
	input  logic        [ptcf_pkg::COLOR_W-1:0]    chan_blue,
	input  logic        [ptcf_pkg::COLOR_W-1:0]    chan_green,
	input  logic        [ptcf_pkg::COLOR_W-1:0]    chan_red,
	output logic                                   o_valid,
	input  logic                                   o_ready,
	output ptcf_pkg::rot_pt_t                      o_pt
);
	import ptcf_pkg::*;

	logic signed [COEF_BITS-1:0]  coef [3][3];
	logic signed [COORD_BITS-1:0] cam [3];
	logic signed [PROD_W-1:0]     prod_s1 [3][3];
	logic [COLOR_W-1:0]           blue_s1, green_s1, red_s1;
	logic                         v_s1, v_s2;
	logic                         en_s1, en_s2;
	logic signed [SUM_W-1:0]      row_sum [3];
	logic signed [SUM_W-1:0]      row_shr [3];
	logic signed [ROT_W-1:0]      row_rot [3];
	rot_pt_t                      pt_s2;

	// stage enables: a stage loads when it is empty or its successor loads
	assign en_s2    = !v_s2 || o_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign o_valid  = v_s2;
	assign o_pt     = pt_s2;

	// unpack matrix and point
	always_comb begin
		cam[0] = cam_x;
		cam[1] = cam_y;
		cam[2] = cam_z;
		for (int k = 0; k < 3; k++) begin
			coef[0][k] = coef_field(cfg.rot_x, k);
			coef[1][k] = coef_field(cfg.rot_y, k);
			coef[2][k] = coef_field(cfg.rot_z, k);
		end
	end

	// row sums, round half up, drop fraction bits
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1]) +
				SUM_W'(prod_s1[r][2]) + RND_HALF;
			row_shr[r] = row_sum[r] >>> KFRAC;
			row_rot[r] = row_shr[r][ROT_W-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage 1: nine products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= coef[r][k] * cam[k];
				end
			end
			blue_s1  <= chan_blue;
			green_s1 <= chan_green;
			red_s1   <= chan_red;
		end
	end

	// stage 2: rotated point
	always_ff @(posedge clk) begin
		if (en_s2) begin
			pt_s2.px    <= row_rot[0];
			pt_s2.py    <= row_rot[1];
			pt_s2.pz    <= row_rot[2];
			pt_s2.blue  <= blue_s1;
			pt_s2.green <= green_s1;
			pt_s2.red   <= red_s1;
		end
	end

	// request refused only with both stages occupied
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2)
		else $error("rotate stalls with an empty stage");

	// a held stage 1 item survives the stall
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en_s2 |=> v_s1)
		else $error("stage 1 item lost during stall");

	// a refused stage 2 item stays put
	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !o_ready |=> v_s2 && $stable(pt_s2))
		else $error("stage 2 item changed while stalled");

endmodule

>>> rtl/core/ptcf_crop.sv
// crop stages: offset and cross products, then rule check and output register
module ptcf_crop (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ptcf_pkg::cfg_t                         cfg,
	input  logic                                   i_valid,
	output logic                                   i_ready,
	input  ptcf_pkg::rot_pt_t                      i_pt,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ptcf_pkg::COORD_BITS-1:0] body_x,
	output logic signed [ptcf_pkg::COORD_BITS-1:0] body_y,
	output logic signed [ptcf_pkg::COORD_BITS-1:0] body_z,
	output logic        [ptcf_pkg::COLOR_W-1:0]    red,
	output logic        [ptcf_pkg::COLOR_W-1:0]    green,
	output logic        [ptcf_pkg::COLOR_W-1:0]    blue
);
	import ptcf_pkg::*;

	logic                         v_s3, v_s4;
	logic                         en_s3, en_s4;
	logic [MAG_W-1:0]             mag_x, mag_y, mag_z;
	logic signed [ROT_W-1:0]      px_s3, py_s3;
	logic [MAG_W-1:0]             mpx_s3, mpy_s3, mpz_s3;
	logic signed [BODY_W-1:0]     bx_s3, by_s3, bz_s3;
	logic [CROSS_W-1:0]           k40_px_s3, k40_py_s3, side_px_s3, side_py_s3, back_px_s3;
	logic [COLOR_W-1:0]           blue_s3, green_s3, red_s3;
	logic                         keep;
	logic                         pass_mode;
	logic signed [COORD_BITS-1:0] bx_s4, by_s4, bz_s4;
	logic [COLOR_W-1:0]           blue_s4, green_s4, red_s4;

	// stage enables
	assign en_s4   = !v_s4 || out_ready;
	assign en_s3   = !v_s3 || en_s4;
	assign i_ready = en_s3;

	assign mag_x = mag_rot(i_pt.px);
	assign mag_y = mag_rot(i_pt.py);
	assign mag_z = mag_rot(i_pt.pz);

	// crop rule of the current mode
	always_comb begin
		case (cfg.mode)
			MODE_FRONT: begin
				keep = !(bz_s3 > LIM_015 || px_s3 < LIM_005 ||
					below(mpx_s3, mpy_s3, k40_py_s3) ||
					!(py_s3 < LIM_050 && py_s3 > LIM_N050));
			end
			MODE_CHIN: begin
				keep = !(below(mpz_s3, mpx_s3, side_px_s3) ||
					below(mpz_s3, mpy_s3, side_py_s3) ||
					(below(mpz_s3, mpx_s3, back_px_s3) && px_s3[ROT_W-1]));
			end
			MODE_LEFT: begin
				keep = !(bz_s3 > LIM_015 || below(mpy_s3, mpx_s3, k40_px_s3) ||
					!(py_s3 > LIM_010 && px_s3 < LIM_035 && px_s3 > LIM_N035));
			end
			MODE_RIGHT: begin
				keep = !(bz_s3 > LIM_015 || below(mpy_s3, mpx_s3, k40_px_s3) ||
					!(py_s3 < LIM_N010 && px_s3 < LIM_035 && px_s3 > LIM_N035));
			end
			MODE_REAR_DOWN: begin
				keep = !(below(mpz_s3, mpy_s3, side_py_s3) ||
					below(mpz_s3, mpx_s3, side_px_s3) ||
					!(bz_s3 < LIM_N005 && by_s3 >= LIM_N035 && by_s3 <= LIM_035 &&
					  bx_s3 < LIM_080 && bx_s3 > LIM_N080));
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	// modes without a crop rule
	assign pass_mode = !(cfg.mode == MODE_FRONT || cfg.mode == MODE_CHIN ||
		cfg.mode == MODE_LEFT || cfg.mode == MODE_RIGHT ||
		cfg.mode == MODE_REAR_DOWN);

	// valid bits, dropped points leave a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= i_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3 && keep;
			end
		end
	end

	// stage 3: body point, magnitudes and cross products
	always_ff @(posedge clk) begin
		if (en_s3) begin
			px_s3      <= i_pt.px;
			py_s3      <= i_pt.py;
			mpx_s3     <= mag_x;
			mpy_s3     <= mag_y;
			mpz_s3     <= mag_z;
			bx_s3      <= BODY_W'(i_pt.px) + BODY_W'(coord_field(cfg.offset, 0));
			by_s3      <= BODY_W'(i_pt.py) + BODY_W'(coord_field(cfg.offset, 1));
			bz_s3      <= BODY_W'(i_pt.pz) + BODY_W'(coord_field(cfg.offset, 2));
			k40_px_s3  <= tan_mul(TAN40, mag_x);
			k40_py_s3  <= tan_mul(TAN40, mag_y);
			side_px_s3 <= tan_mul(cfg.tan_side, mag_x);
			side_py_s3 <= tan_mul(cfg.tan_side, mag_y);
			back_px_s3 <= tan_mul(cfg.tan_back, mag_x);
			blue_s3    <= i_pt.blue;
			green_s3   <= i_pt.green;
			red_s3     <= i_pt.red;
		end
	end

	// stage 4: saturated output register
	always_ff @(posedge clk) begin
		if (en_s4) begin
			bx_s4    <= sat_coord(bx_s3);
			by_s4    <= sat_coord(by_s3);
			bz_s4    <= sat_coord(bz_s3);
			blue_s4  <= blue_s3;
			green_s4 <= green_s3;
			red_s4   <= red_s3;
		end
	end

	assign out_valid = v_s4;
	assign body_x    = bx_s4;
	assign body_y    = by_s4;
	assign body_z    = bz_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

	// request refused only with both stages occupied
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!i_ready |-> v_s3 && v_s4)
		else $error("crop stalls with an empty stage");

	// unknown modes keep every point
	a_pass_all: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en_s4 && pass_mode |=> v_s4)
		else $error("point dropped in a pass-all mode");

	// rear-down never keeps a point at or above the height limit
	a_rear_height: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en_s4 && cfg.mode == MODE_REAR_DOWN && bz_s3 >= LIM_N005 |=> !v_s4)
		else $error("rear-down kept a high point");

endmodule

>>> rtl/core/point_transform_crop_filter.sv
// top level of the point transform crop filter: config registers and pipeline
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one register
//   per request: 0 mount mode, 1..3 rotation rows, 4 offset, 5 side tangent,
//   6 rear tangent; other indexes are ignored. cfg_ready is always high. Write
//   only while no point is in flight.
//   Input channel (in_valid/in_ready) takes one camera point and colour per
//   request. Output channel (out_valid/out_ready) gives body coordinates and
//   colour of each kept point; a cropped point gives no output request.
//   A kept point passes the product, row sum, offset and cross product, and
//   crop and saturation stages in that order and is presented from the output
//   register until out_ready is high. Throughput: one point per cycle while
//   in_ready is high.
//   When the receiver stalls, the output register holds its point and stages
//   behind it keep filling empty slots; in_ready falls only with all four
//   stages occupied.
//   Reset: pipeline empty, mount mode front, all other registers zero.
module point_transform_crop_filter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ptcf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ptcf_pkg::REG_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [ptcf_pkg::COORD_BITS-1:0] cam_x,
	input  logic signed [ptcf_pkg::COORD_BITS-1:0] cam_y,
	input  logic signed [ptcf_pkg::COORD_BITS-1:0] cam_z,
	input  logic        [ptcf_pkg::COLOR_W-1:0]    chan_blue,
	input  logic        [ptcf_pkg::COLOR_W-1:0]    chan_green,
	input  logic        [ptcf_pkg::COLOR_W-1:0]    chan_red,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ptcf_pkg::COORD_BITS-1:0] body_x,
	output logic signed [ptcf_pkg::COORD_BITS-1:0] body_y,
	output logic signed [ptcf_pkg::COORD_BITS-1:0] body_z,
	output logic        [ptcf_pkg::COLOR_W-1:0]    red,
	output logic        [ptcf_pkg::COLOR_W-1:0]    green,
	output logic        [ptcf_pkg::COLOR_W-1:0]    blue
);
	import ptcf_pkg::*;

	cfg_t    cfg_q;
	logic    rot_valid, rot_ready;
	rot_pt_t rot_pt;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_RESET;
			cfg_q.rot_x    <= '0;
			cfg_q.rot_y    <= '0;
			cfg_q.rot_z    <= '0;
			cfg_q.offset   <= '0;
			cfg_q.tan_side <= '0;
			cfg_q.tan_back <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MOUNT_MODE: cfg_q.mode     <= cfg_data[MODE_W-1:0];
				REG_ROT_ROW_X:  cfg_q.rot_x    <= cfg_data;
				REG_ROT_ROW_Y:  cfg_q.rot_y    <= cfg_data;
				REG_ROT_ROW_Z:  cfg_q.rot_z    <= cfg_data;
				REG_OFFSET_XYZ: cfg_q.offset   <= cfg_data;
				REG_TAN_SIDE:   cfg_q.tan_side <= cfg_data[TAN_W-1:0];
				REG_TAN_BACK:   cfg_q.tan_back <= cfg_data[TAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// rotation stages
	ptcf_rotate u_rotate (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cam_x      (cam_x),
		.cam_y      (cam_y),
		.cam_z      (cam_z),
		.chan_blue  (chan_blue),
		.chan_green (chan_green),
		.chan_red   (chan_red),
		.o_valid    (rot_valid),
		.o_ready    (rot_ready),
		.o_pt       (rot_pt)
	);

	// crop stages and output register
	ptcf_crop u_crop (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.i_valid   (rot_valid),
		.i_ready   (rot_ready),
		.i_pt      (rot_pt),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.body_x    (body_x),
		.body_y    (body_y),
		.body_z    (body_z),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule
